FILE: rtl/par_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_pkg
// Shared types and constants for the polyphase audio resampler.
// ----------------------------------------------------------------------------
package par_pkg;

    localparam int STEP_W    = 21;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int CIDX_W    = 12;
    localparam int FRAC_W    = 16;
    localparam int LAG_W     = 5;
    localparam int MAX_OUT   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_MODE  = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_SHIFT,
        t_ST_CHECK,
        t_ST_MAC,
        t_ST_DRAIN,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        logic [CIDX_W-1:0]   coef_index;
        logic [COEF_W-1:0]   coef_value;
    } t_in_word;

    typedef struct packed {
        logic [SAMPLE_W-1:0] out_sample;
        logic                last_of_run;
    } t_out_word;

endpackage

FILE: rtl/par_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface par_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/par_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// par_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module par_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/polyphase_audio_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_audio_resampler
// Single-channel polyphase FIR resampler with one shared MAC.
// ----------------------------------------------------------------------------
// channel   dir  payload
// i_in      in   kind, sample, coef_index, coef_value
// o_out     out  out_sample, last_of_run
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// Coefficient words write the bank RAM. A sample shifts into the window, then
// each output uses one MAC per tap (bank and window RAM reads registered), up
// to 16 outputs. Reset clears position, fill count and window head (an
// unfilled window is never read, so window RAM needs no clear). Ready is low
// while an item is worked; each output waits in the output register until taken.
// ----------------------------------------------------------------------------
module polyphase_audio_resampler
    import par_pkg::*;
#(
    parameter int TAPS   = 128,
    parameter int PHASES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [STEP_W-1:0]     i_cfg_data,
    par_stream_if.sink            i_in,
    par_stream_if.source          o_out
);
    localparam int TW    = $clog2(TAPS);
    localparam int PW    = $clog2(PHASES);
    localparam int BANK  = TAPS * PHASES;
    localparam int BW    = $clog2(BANK);
    localparam int FILLW = $clog2(TAPS + 1);
    localparam int ACCW  = 32 + TW + 2;
    localparam int CNTW  = $clog2(MAX_OUT + 1);

    t_state r_state, n_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_byte;
    logic [FILLW-1:0]    r_fill;
    logic [FRAC_W-1:0]   r_frac;
    logic [LAG_W-1:0]    r_lag;
    logic [TW-1:0]       r_head;   // window RAM address of oldest sample
    logic [TW:0]         r_tap;    // read issue counter
    logic [TW:0]         r_mcnt;   // accumulated products
    logic [1:0]          r_pipe;
    logic signed [ACCW-1:0] r_acc;
    logic signed [31:0]  r_prod;
    logic [CNTW-1:0]     r_nout;
    logic [SAMPLE_W-1:0] r_s;
    logic                r_ovalid;
    t_out_word           r_odata;
    logic                o_busy;

    // ---------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_W'(32'h10000);
            r_byte <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PHASE_STEP: r_step <= i_cfg_data;
                CFG_BYTE_MODE:  r_byte <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- memories
    logic              bank_we;
    logic [BW-1:0]     bank_raddr;
    logic [COEF_W-1:0] bank_rdata;
    logic              win_we;
    logic [TW-1:0]     win_waddr, win_raddr;
    logic [SAMPLE_W-1:0] win_rdata;
    logic              acc_in;

    assign acc_in  = i_in.valid && i_in.ready;
    assign bank_we = acc_in && i_in.data.kind == KIND_COEF
                     && {1'b0, i_in.data.coef_index} < (CIDX_W+1)'(BANK);

    par_ram #(.WIDTH(COEF_W), .DEPTH(BANK)) u_bank (
        .i_clk(i_clk), .i_we(bank_we),
        .i_waddr(BW'(i_in.data.coef_index)), .i_wdata(i_in.data.coef_value),
        .i_raddr(bank_raddr), .o_rdata(bank_rdata)
    );

    // window stored as a circular buffer; written in SHIFT
    assign win_we    = r_state == t_ST_SHIFT;
    assign win_waddr = (r_fill < FILLW'(TAPS)) ? TW'(r_fill) : r_head;
    assign win_raddr = r_head + r_tap[TW-1:0];
    assign bank_raddr = BW'({r_frac[FRAC_W-1 -: PW], r_tap[TW-1:0]})
                        ;

    par_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_win (
        .i_clk(i_clk), .i_we(win_we), .i_waddr(win_waddr), .i_wdata(r_s),
        .i_raddr(win_raddr), .o_rdata(win_rdata)
    );

    // ---------------- next state
    logic full;
    assign full = r_fill == FILLW'(TAPS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_ST_IDLE:  if (acc_in && i_in.data.kind == KIND_SAMPLE) n_state = t_ST_SHIFT;
            t_ST_SHIFT: n_state = t_ST_CHECK;
            t_ST_CHECK: n_state = (full && r_lag == '0 && r_nout != CNTW'(MAX_OUT))
                                  ? t_ST_MAC : t_ST_IDLE;
            t_ST_MAC:   if (r_tap == (TW+1)'(TAPS)) n_state = t_ST_DRAIN;
            t_ST_DRAIN: if (r_mcnt == (TW+1)'(TAPS)) n_state = t_ST_OUT;
            t_ST_OUT:   if (!r_ovalid) n_state = t_ST_CHECK;
            default:    n_state = t_ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = r_state != t_ST_IDLE || r_ovalid;
    end
    assign i_in.ready = !o_busy;

    // saturation of final sum
    logic signed [ACCW-15:0] q;
    logic [SAMPLE_W-1:0] sat;
    assign q = (ACCW-14)'(r_acc >>> 14);
    always_comb begin
        if (q > (ACCW-14)'(32767))        sat = 16'h7FFF;
        else if (q < -(ACCW-14)'(32768))  sat = 16'h8000;
        else                              sat = q[SAMPLE_W-1:0];
    end

    logic [FRAC_W+LAG_W:0] pos;
    assign pos = (FRAC_W+LAG_W+1)'(r_frac) + (FRAC_W+LAG_W+1)'(r_step);

    logic last_now;  // does this output end the run?
    logic [FRAC_W+LAG_W:0] lag_full;
    assign lag_full = pos >> FRAC_W;
    assign last_now = lag_full != '0 || r_nout == CNTW'(MAX_OUT - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= t_ST_IDLE;
            r_fill   <= '0;
            r_frac   <= '0;
            r_lag    <= '0;
            r_head   <= '0;
            r_ovalid <= 1'b0;
            r_pipe   <= '0;
            r_nout   <= '0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
            r_pipe <= {r_pipe[0], r_state == t_ST_MAC && r_tap != (TW+1)'(TAPS)};
            unique case (r_state)
                t_ST_IDLE: begin
                    r_nout <= '0;
                    if (acc_in) begin
                        r_s <= r_byte ? SAMPLE_W'({i_in.data.sample[7:0], 8'h00} ^ 16'h8000)
                                      : i_in.data.sample;
                    end
                end
                t_ST_SHIFT: begin
                    if (full) begin
                        r_head <= r_head + 1'b1;
                        if (r_lag != '0) r_lag <= r_lag - 1'b1;
                    end else begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                t_ST_CHECK: begin
                    r_tap  <= '0;
                    r_mcnt <= '0;
                    r_acc  <= ACCW'(32'sh2000);
                end
                t_ST_MAC, t_ST_DRAIN: begin
                    if (r_state == t_ST_MAC && r_tap != (TW+1)'(TAPS)) r_tap <= r_tap + 1'b1;
                    if (r_pipe[0]) r_prod <= $signed(bank_rdata) * $signed(win_rdata);
                    if (r_pipe[1]) begin
                        r_acc  <= r_acc + ACCW'(r_prod);
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
                t_ST_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata.out_sample  <= sat;
                        r_odata.last_of_run <= last_now;
                        r_nout <= r_nout + 1'b1;
                        r_frac <= pos[FRAC_W-1:0];
                        r_lag  <= (lag_full > (FRAC_W+LAG_W+1)'(31)) ? LAG_W'(31)
                                                                     : LAG_W'(lag_full);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // ---------------- assertions
    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILLW'(TAPS)) else $error("fill overflow");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != t_ST_IDLE |-> !i_in.ready) else $error("ready while busy");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nout <= CNTW'(MAX_OUT)) else $error("result cap exceeded");
    a_mac_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == t_ST_MAC |-> full) else $error("MAC on partial window");
endmodule
